[rtl/core/mqts_pkg.sv]
// ============================================================================
// mqts_pkg
// Shared codes and control/status bundles for the max queue built from two
// stacks.
// ============================================================================
`default_nettype none

package mqts_pkg;

    // Operation codes carried by a request transaction.
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_MAX = 2'd2;

    // Status codes carried by a response transaction.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Response source select, from the controller to the datapath.
    localparam logic [2:0] RSP_OK    = 3'd0;
    localparam logic [2:0] RSP_FULL  = 3'd1;
    localparam logic [2:0] RSP_EMPTY = 3'd2;
    localparam logic [2:0] RSP_MAX   = 3'd3;
    localparam logic [2:0] RSP_POP   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ready;      // request channel may take a transaction
        logic       load;       // load the response register
        logic [2:0] rsel;       // response source
        logic       push_in;    // push the held value onto the in-stack
        logic       pop_rd;     // read the top of the out-stack
        logic       pop_fin;    // finish the out-stack pop
        logic       xfer_rd;    // read the top of the in-stack
        logic       xfer_pop;   // finish the in-stack pop, hold the entry
        logic       xfer_push;  // push the held entry onto the out-stack
    } mqts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;         // held operation code
        logic       full;       // both stacks together hold the capacity
        logic       in_empty;   // in-stack has no entries
        logic       out_empty;  // out-stack has no entries
        logic       out_free;   // response register can be loaded this cycle
    } mqts_sts_t;

endpackage

`default_nettype wire

[rtl/core/mqts_if.sv]
// ============================================================================
// mqts_if
// Request and response channel interfaces with valid/ready handshakes.
// ============================================================================
`default_nettype none

// Request channel: operation and value to enqueue.
interface mqts_req_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: dequeued value or maximum, and status.
interface mqts_rsp_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] result_value;
    logic [1:0]            status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/mqts_ram.sv]
// ============================================================================
// mqts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module mqts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/mqts_ctrl.sv]
// ============================================================================
// mqts_ctrl
// Controller state machine: sequences enqueue, dequeue, stack transfer and
// maximum query, and issues commands to the datapath.
// ============================================================================
`default_nettype none

module mqts_ctrl
    import mqts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire mqts_sts_t sts,
    output mqts_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_XPOP  = 3'd3;
    localparam logic [2:0] S_XPUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = RSP_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_ENQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load = 1'b1;
                            if (sts.full)
                            begin
                                cmd.rsel = RSP_FULL;
                            end
                            else
                            begin
                                cmd.push_in = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (!sts.out_empty)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP;
                        end
                        else if (!sts.in_empty)
                        begin
                            cmd.xfer_rd = 1'b1;
                            state_next  = S_XPOP;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.load   = 1'b1;
                            cmd.rsel   = RSP_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    OP_MAX:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load   = 1'b1;
                            cmd.rsel   = RSP_MAX;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    cmd.pop_fin = 1'b1;
                    cmd.load    = 1'b1;
                    cmd.rsel    = RSP_POP;
                    state_next  = S_IDLE;
                end
            end
            S_XPOP:
            begin
                cmd.xfer_pop = 1'b1;
                state_next   = S_XPUSH;
            end
            S_XPUSH:
            begin
                // The next in-stack read overlaps this push.
                cmd.xfer_push = 1'b1;
                if (!sts.in_empty)
                begin
                    cmd.xfer_rd = 1'b1;
                    state_next  = S_XPOP;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/mqts_dp.sv]
// ============================================================================
// mqts_dp
// Datapath: the two difference stacks, their depths and running maxima, the
// transfer holding register and the response register.
// ============================================================================
`default_nettype none

module mqts_dp
    import mqts_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mqts_cmd_t             cmd,
    output mqts_sts_t                  sts,
    input  wire logic [1:0]            in_operation,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic      [VALUE_BITS-1:0] out_result_value,
    output logic      [1:0]            out_status
);

    localparam int VB = VALUE_BITS;
    localparam int DB = VALUE_BITS + 1;
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = $clog2(CAPACITY + 1);

    logic [1:0]    op_reg;
    logic [VB-1:0] val_reg;
    logic [DW-1:0] in_depth_reg;
    logic [DW-1:0] out_depth_reg;
    logic [VB-1:0] in_max_reg;
    logic [VB-1:0] out_max_reg;
    logic [VB-1:0] e_reg;
    logic          out_valid_reg;
    logic [VB-1:0] res_val_reg;
    logic [1:0]    res_st_reg;

    logic [DW-1:0] in_depth_m1;
    logic [DW-1:0] out_depth_m1;
    logic [DW:0]   total;
    logic [DB-1:0] in_wdata;
    logic [DB-1:0] out_wdata;
    logic [DB-1:0] in_rdata;
    logic [DB-1:0] out_rdata;
    logic [VB-1:0] in_pop_val;
    logic [VB-1:0] in_pop_max;
    logic [VB-1:0] out_pop_val;
    logic [VB-1:0] out_pop_max;
    logic [VB-1:0] q_max;
    logic [VB-1:0] res_val_next;
    logic [1:0]    res_st_next;

    assign in_depth_m1  = in_depth_reg - DW'(1);
    assign out_depth_m1 = out_depth_reg - DW'(1);
    assign total        = {1'b0, in_depth_reg} + {1'b0, out_depth_reg};

    // Status toward the controller.
    assign sts.op        = op_reg;
    assign sts.full      = (total >= (DW + 1)'(CAPACITY));
    assign sts.in_empty  = (in_depth_reg == '0);
    assign sts.out_empty = (out_depth_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Differences from the running maximum at push time.
    assign in_wdata  = {1'b0, val_reg} - {1'b0, in_max_reg};
    assign out_wdata = {1'b0, e_reg} - {1'b0, out_max_reg};

    // A non-negative difference marks the entry that set the maximum.
    assign in_pop_val  = in_rdata[DB-1] ? in_max_reg + in_rdata[VB-1:0] : in_max_reg;
    assign in_pop_max  = in_rdata[DB-1] ? in_max_reg : in_max_reg - in_rdata[VB-1:0];
    assign out_pop_val = out_rdata[DB-1] ? out_max_reg + out_rdata[VB-1:0] : out_max_reg;
    assign out_pop_max = out_rdata[DB-1] ? out_max_reg : out_max_reg - out_rdata[VB-1:0];

    assign q_max = (in_max_reg >= out_max_reg) ? in_max_reg : out_max_reg;

    // Stack storage.
    mqts_ram #(
        .WIDTH (DB),
        .DEPTH (CAPACITY)
    ) u_in_ram (
        .clk   (clk),
        .we    (cmd.push_in),
        .waddr (in_depth_reg[AW-1:0]),
        .wdata (in_wdata),
        .re    (cmd.xfer_rd),
        .raddr (in_depth_m1[AW-1:0]),
        .rdata (in_rdata)
    );

    mqts_ram #(
        .WIDTH (DB),
        .DEPTH (CAPACITY)
    ) u_out_ram (
        .clk   (clk),
        .we    (cmd.xfer_push),
        .waddr (out_depth_reg[AW-1:0]),
        .wdata (out_wdata),
        .re    (cmd.pop_rd),
        .raddr (out_depth_m1[AW-1:0]),
        .rdata (out_rdata)
    );

    // Held request fields, transfer entry and response register.
    always_ff @(posedge clk)
    begin
        if (cmd.ready)
        begin
            op_reg  <= in_operation;
            val_reg <= in_value;
        end
        if (cmd.xfer_pop)
        begin
            e_reg <= in_pop_val;
        end
        if (cmd.load)
        begin
            res_val_reg <= res_val_next;
            res_st_reg  <= res_st_next;
        end
    end

    // Stack depths and running maxima.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_depth_reg  <= '0;
            out_depth_reg <= '0;
            in_max_reg    <= '0;
            out_max_reg   <= '0;
        end
        else
        begin
            if (cmd.push_in)
            begin
                in_depth_reg <= in_depth_reg + DW'(1);
                if (val_reg > in_max_reg)
                begin
                    in_max_reg <= val_reg;
                end
            end
            if (cmd.xfer_rd)
            begin
                in_depth_reg <= in_depth_m1;
            end
            if (cmd.xfer_pop)
            begin
                in_max_reg <= in_pop_max;
            end
            if (cmd.xfer_push)
            begin
                out_depth_reg <= out_depth_reg + DW'(1);
                if (e_reg > out_max_reg)
                begin
                    out_max_reg <= e_reg;
                end
            end
            if (cmd.pop_rd)
            begin
                out_depth_reg <= out_depth_m1;
            end
            if (cmd.pop_fin)
            begin
                out_max_reg <= out_pop_max;
            end
        end
    end

    // Response selection.
    always_comb
    begin
        res_val_next = '0;
        res_st_next  = ST_OK;
        case (cmd.rsel)
            RSP_OK:
            begin
                res_st_next = ST_OK;
            end
            RSP_FULL:
            begin
                res_st_next = ST_FULL;
            end
            RSP_EMPTY:
            begin
                res_st_next = ST_EMPTY;
            end
            RSP_MAX:
            begin
                res_val_next = q_max;
            end
            RSP_POP:
            begin
                res_val_next = out_pop_val;
            end
            default:
            begin
                res_val_next = '0;
            end
        endcase
    end

    // Response register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_result_value = res_val_reg;
    assign out_status       = res_st_reg;

endmodule

`default_nettype wire

[rtl/core/max_queue_two_stacks.sv]
// ============================================================================
// max_queue_two_stacks
// FIFO queue of non-negative values with a maximum query, built from an
// in-stack and an out-stack that store differences from running maxima.
// ============================================================================
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid / ready  operation[1:0], value[VALUE_BITS-1:0]
//   rsp      out  valid / ready  result_value[VALUE_BITS-1:0], status[1:0]
//
// Enqueue, maximum query and unused codes pass through the idle and execute
// states; a dequeue with a non-empty out-stack adds a pop state because of
// the registered RAM read. A dequeue that finds the out-stack empty first
// moves each in-stack entry across (read, then push overlapped with next read).
// Reset clears depths and maxima at once; the stack RAMs are not cleared.
// A result waits in the response register while the next transaction is
// taken; execution stalls only when a new result meets a full register.
//
`default_nettype none

module max_queue_two_stacks
    import mqts_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 31
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mqts_req_if.sink   req,
    mqts_rsp_if.source rsp
);

    mqts_cmd_t cmd;
    mqts_sts_t sts;

    // Request handshake.
    assign req.ready = cmd.ready;

    // Sequencing.
    mqts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    mqts_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_operation     (req.operation),
        .in_value         (req.value),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_result_value (rsp.result_value),
        .out_status       (rsp.status)
    );

endmodule

`default_nettype wire

[test/max_queue_two_stacks_tb.sv]
// ============================================================================
// max_queue_two_stacks_tb
// Drives enqueue, dequeue, maximum and unused operations through the request
// channel and checks every response against a two-stack predictor kept in
// the testbench. A short directed run comes first. Random traffic follows,
// along with a fill up to capacity and a drain back to empty. Both channels
// idle at random.
// ============================================================================

module max_queue_two_stacks_tb;
    import mqts_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_BITS  = 31;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_MAX    = 19;
    localparam int STRETCH     = 40;
    localparam int DRAIN_WAIT  = 30;

    // Operation code with no function in the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Stack indexes of the predictor.
    localparam int IN_STK  = 0;
    localparam int OUT_STK = 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result_value;
        logic [1:0]            status;
    } qresult_t;

    logic clk;
    logic rst_n;

    mqts_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    mqts_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

    max_queue_two_stacks #(
        .CAPACITY  (CAPACITY),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Predictor state: per stack, the differences from the running maximum.
    longint                stack_diff  [2][CAPACITY];
    int                    stack_depth [2];
    logic [VALUE_BITS-1:0] stack_max   [2];

    qresult_t expected_results[$];
    int       errors;
    int       cycle_count;
    int       sent_count;
    bit       src_steady;
    bit       snk_steady;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Number of entries held by both stacks together.
    function automatic int queued();
        return stack_depth[IN_STK] + stack_depth[OUT_STK];
    endfunction

    // Push a value, storing its difference from the stack maximum.
    function automatic void pred_push(input int s, input logic [VALUE_BITS-1:0] e);
        longint ev;
        longint mv;
        ev = e;
        mv = stack_max[s];
        stack_diff[s][stack_depth[s]] = ev - mv;
        stack_depth[s]++;
        if (e > stack_max[s])
        begin
            stack_max[s] = e;
        end
    endfunction

    // Pop a value; a non-negative difference marks the entry that set the maximum.
    function automatic logic [VALUE_BITS-1:0] pred_pop(input int s);
        longint d;
        longint mv;
        logic [VALUE_BITS-1:0] r;
        stack_depth[s]--;
        d  = stack_diff[s][stack_depth[s]];
        mv = stack_max[s];
        if (d >= 0)
        begin
            r            = stack_max[s];
            stack_max[s] = VALUE_BITS'(mv - d);
        end
        else
        begin
            r = VALUE_BITS'(mv + d);
        end
        return r;
    endfunction

    // Apply one request to the predictor and return the response it must cause.
    function automatic qresult_t predict_result(input logic [1:0] op,
                                                input logic [VALUE_BITS-1:0] v);
        qresult_t r;
        r.result_value = '0;
        r.status       = ST_OK;
        case (op)
            OP_ENQ:
            begin
                if (queued() >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pred_push(IN_STK, v);
                end
            end
            OP_DEQ:
            begin
                if (stack_depth[OUT_STK] == 0)
                begin
                    while (stack_depth[IN_STK] > 0 && stack_depth[OUT_STK] < CAPACITY)
                    begin
                        pred_push(OUT_STK, pred_pop(IN_STK));
                    end
                end
                if (stack_depth[OUT_STK] == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.result_value = pred_pop(OUT_STK);
                end
            end
            OP_MAX:
            begin
                r.result_value = (stack_max[IN_STK] >= stack_max[OUT_STK]) ?
                                 stack_max[IN_STK] : stack_max[OUT_STK];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Random value biased toward the small end, the top end and single bits.
    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [VALUE_BITS-1:0] top;
        logic [VALUE_BITS-1:0] v;
        top = '1;
        case ($urandom_range(0, 4))
            0: v = VALUE_BITS'($urandom_range(0, 15));
            1: v = top - VALUE_BITS'($urandom_range(0, 15));
            2: v = VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
            default: v = VALUE_BITS'($urandom);
        endcase
        return v;
    endfunction

    // Pick an operation by percentage; the remainder below 98 goes to maximum queries, the rest to the unused code.
    function automatic logic [1:0] pick_op(input int enq_pct, input int deq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
        begin
            return OP_ENQ;
        end
        if (r < enq_pct + deq_pct)
        begin
            return OP_DEQ;
        end
        if (r < 98)
        begin
            return OP_MAX;
        end
        return OP_UNUSED;
    endfunction

    // Send one request transaction and record the response it must cause.
    // Valid stays high after acceptance so back-to-back requests need no toggle.
    task automatic send_request(input logic [1:0] op, input logic [VALUE_BITS-1:0] v);
        int gap;
        sent_count++;
        if (sent_count % STRETCH == 0)
        begin
            src_steady = ($urandom_range(0, 2) == 0);
        end
        gap = src_steady ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= v;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        expected_results.push_back(predict_result(op, v));
    endtask

    // Empty queue, extremes of the value, the unused code and a transfer.
    task automatic test_directed();
        logic [VALUE_BITS-1:0] top;
        top = '1;
        send_request(OP_DEQ, top);
        send_request(OP_MAX, top);
        send_request(OP_UNUSED, top);
        send_request(OP_ENQ, '0);
        send_request(OP_MAX, '0);
        send_request(OP_ENQ, top);
        send_request(OP_ENQ, VALUE_BITS'(1));
        send_request(OP_MAX, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_ENQ, VALUE_BITS'(5));
        send_request(OP_MAX, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_MAX, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_MAX, '0);
        send_request(OP_ENQ, VALUE_BITS'(31'h2AAAAAAA));
        send_request(OP_ENQ, VALUE_BITS'(31'h55555555));
        send_request(OP_MAX, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_UNUSED, '0);
    endtask

    // Random mix of operations with the queue kept shallow.
    task automatic test_mixed_traffic(input int count, input int enq_pct, input int deq_pct);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_request(pick_op(enq_pct, deq_pct), rand_value());
        end
    endtask

    // Fill to capacity with entries on both stacks, then push against the limit.
    task automatic test_fill_to_capacity();
        int i;
        for (i = 0; i < 20; i++)
        begin
            send_request(OP_ENQ, rand_value());
        end
        send_request(OP_DEQ, rand_value());
        while (queued() < CAPACITY)
        begin
            send_request(($urandom_range(0, 99) < 1) ? OP_MAX : OP_ENQ, rand_value());
        end
        for (i = 0; i < 6; i++)
        begin
            send_request(OP_ENQ, rand_value());
        end
        send_request(OP_MAX, rand_value());
        send_request(OP_DEQ, rand_value());
        send_request(OP_ENQ, rand_value());
        send_request(OP_ENQ, rand_value());
    endtask

    // Drain the full queue back to empty, then dequeue past the end.
    task automatic test_drain_to_empty();
        int i;
        while (queued() > 0)
        begin
            send_request(pick_op(1, 97), rand_value());
        end
        for (i = 0; i < 3; i++)
        begin
            send_request(OP_DEQ, rand_value());
        end
    endtask

    // Response side: random stalls, then compare each transaction with the
    // oldest expectation.
    initial
    begin
        int       stall;
        int       got_count;
        qresult_t want;
        got_count     = 0;
        rsp_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            got_count++;
            if (got_count % STRETCH == 0)
            begin
                snk_steady = ($urandom_range(0, 2) == 0);
            end
            stall = snk_steady ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_ch.valid);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected response: result_value %0d status %0d",
                         $time, rsp_ch.result_value, rsp_ch.status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.result_value !== want.result_value)
                begin
                    $display("%0t: result_value mismatch: expected %0d, actual %0d",
                             $time, want.result_value, rsp_ch.result_value);
                    errors++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("max_queue_two_stacks_tb: FAIL");
        $finish;
    end

    // Reset, run the tests in turn, then wait for the last responses.
    initial
    begin
        errors               = 0;
        sent_count           = 0;
        src_steady           = 1'b0;
        snk_steady           = 1'b0;
        stack_depth[IN_STK]  = 0;
        stack_depth[OUT_STK] = 0;
        stack_max[IN_STK]    = '0;
        stack_max[OUT_STK]   = '0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_ENQ;
        req_ch.value         = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_mixed_traffic(40, 50, 35);
        test_fill_to_capacity();
        test_drain_to_empty();
        test_mixed_traffic(20, 45, 40);

        req_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
        begin
            $display("max_queue_two_stacks_tb: PASS");
        end
        else
        begin
            $display("max_queue_two_stacks_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/mqts_pkg.sv
rtl/core/mqts_if.sv
rtl/core/mqts_ram.sv
rtl/core/mqts_ctrl.sv
rtl/core/mqts_dp.sv
rtl/core/max_queue_two_stacks.sv
test/max_queue_two_stacks_tb.sv
